[sv/ternary_min_heap_queue_top_assert.svh]
// Assertion macros for the ternary min-heap queue.
`ifndef TERNARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define TERNARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTH

`define TMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TMHQ_ASSERT_IMP(lbl, ante, cons, msg)

`define TMHQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/tmhq_pkg.sv]
package tmhq_pkg;

  localparam int StoreDepth      = 256;
  localparam int AddrW           = 8;
  localparam int KeyW            = 32;
  localparam int DefaultCapacity = 255;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage

[sv/ternary_min_heap_queue_top.sv]
// Ternary min-heap priority queue.
// Input channel: in_valid_i / in_stall_o carry one transaction with in_kind_i
// (insert or extract minimum) and the signed key in in_key_i.
// Output channel: out_valid_o / out_stall_i return one result per transaction:
// extracted key (zero for insert or error), status (ok, empty, full) and the
// key count after the operation.
// The keys live in one 256-entry single-port-read memory with a registered
// read; every sift step reads one entry at a time, so the memory port sets
// the pace. One transaction is worked at a time.
// An insert climbs from the new leaf: per level it reads the parent, compares,
// and writes either the parent down or the key. An extract reads the root, then
// (unless the queue is now empty) the last entry, and at each node visited reads
// and compares each child in turn before one write. Errors go straight to the
// done state. The next transaction is taken in the cycle after the result is
// registered.
// A finished result waits in an output register; a new transaction is taken
// while it waits, and the block holds its result in the done state only if
// the output register is still full and stalled when the next one finishes.
// Reset empties the queue (count zero) and drops any pending result; memory
// contents are not cleared.
module ternary_min_heap_queue_top
  import tmhq_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_kind_i,
  input  logic signed [31:0] in_key_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic signed [31:0] out_min_key_o,
  output logic [1:0]       out_status_o,
  output logic [7:0]       out_count_o
);

  `include "ternary_min_heap_queue_top_assert.svh"

  localparam int UsableCap = (CAPACITY < 255) ? CAPACITY : 255;
  localparam logic [AddrW-1:0] CapLimit = AddrW'(UsableCap);

  state_e state_q, state_d;
  logic [AddrW-1:0] count_q, count_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] best_q, best_d;
  logic [1:0] j_q, j_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] best_val_q, best_val_d;
  logic signed [KeyW-1:0] res_key_q, res_key_d;
  status_e res_st_q, res_st_d;

  logic [KeyW-1:0] heap_mem_q [StoreDepth];
  logic signed [KeyW-1:0] rd_data_q;
  logic rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic signed [KeyW-1:0] wr_data;

  logic out_valid_q;
  logic signed [KeyW-1:0] out_min_key_q;
  status_e out_status_q;
  logic [AddrW-1:0] out_count_q;

  logic in_acc, out_free;
  logic [16:0] par_prod;
  logic [AddrW-1:0] parent;
  logic [9:0] child;
  logic child_ok;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign par_prod = {8'd0, ({1'b0, pos_q} + 9'd1)} * 17'd171;
  assign parent   = par_prod[16:9];
  assign child    = ({2'b00, pos_q} * 10'd3) - 10'd1 + {8'd0, j_q};
  assign child_ok = (j_q != 2'd3) && (child <= {2'b00, count_q});

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    best_d     = best_q;
    j_d        = j_q;
    key_d      = key_q;
    best_val_d = best_val_q;
    res_key_d  = res_key_q;
    res_st_d   = res_st_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_key_d = '0;
          res_st_d  = ST_OK;
          key_d     = in_key_i;
          if (kind_e'(in_kind_i) == KIND_INSERT) begin
            if (count_q >= CapLimit) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              count_d = count_q + 8'd1;
              pos_d   = count_q + 8'd1;
              state_d = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              count_d = count_q - 8'd1;
              state_d = S_DN_ROOT;
            end
          end
        end
      end
      S_UP: begin
        state_d = (pos_q == 8'd1) ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (key_q < rd_data_q) begin
          pos_d   = parent;
          state_d = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_ROOT: begin
        res_key_d = rd_data_q;
        state_d   = (count_q == '0) ? S_DONE : S_DN_LAST;
      end
      S_DN_LAST: begin
        key_d      = rd_data_q;
        best_val_d = rd_data_q;
        pos_d      = 8'd1;
        best_d     = 8'd1;
        j_d        = 2'd0;
        state_d    = S_DN_RD;
      end
      S_DN_RD: begin
        if (child_ok) begin
          state_d = S_DN_CMP;
        end else if (best_q == pos_q) begin
          state_d = S_DONE;
        end else begin
          pos_d      = best_q;
          best_val_d = key_q;
          j_d        = 2'd0;
        end
      end
      S_DN_CMP: begin
        if (rd_data_q < best_val_q) begin
          best_d     = child[AddrW-1:0];
          best_val_d = rd_data_q;
        end
        j_d     = j_q + 2'd1;
        state_d = S_DN_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = key_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && kind_e'(in_kind_i) == KIND_EXTRACT) begin
          rd_en   = 1'b1;
          rd_addr = 8'd1;
        end
      end
      S_UP: begin
        if (pos_q == 8'd1) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = (key_q < rd_data_q) ? rd_data_q : key_q;
      end
      S_DN_ROOT: begin
        rd_en   = (count_q != '0);
        rd_addr = count_q + 8'd1;
      end
      S_DN_RD: begin
        if (child_ok) begin
          rd_en   = 1'b1;
          rd_addr = child[AddrW-1:0];
        end else begin
          wr_en   = 1'b1;
          wr_data = (best_q == pos_q) ? key_q : best_val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= heap_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    best_q     <= best_d;
    j_q        <= j_d;
    key_q      <= key_d;
    best_val_q <= best_val_d;
    res_key_q  <= res_key_d;
    res_st_q   <= res_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_min_key_q <= res_key_q;
      out_status_q  <= res_st_q;
      out_count_q   <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_min_key_o = out_min_key_q;
  assign out_status_o  = out_status_q;
  assign out_count_o   = out_count_q;

  `TMHQ_ASSERT_NXT(a_acc_busy, in_acc, state_q != S_IDLE,
                   "accepted transaction did not start")
  `TMHQ_ASSERT_IMP(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr,
                   "read and write same entry")
  `TMHQ_ASSERT_IMP(a_cmp_after_rd, state_q == S_UP_CMP || state_q == S_DN_CMP,
                   $past(rd_en), "compare without read")
  `TMHQ_ASSERT_IMP(a_full_count, out_valid_q && out_status_q == ST_FULL,
                   out_count_q == CapLimit, "full reported below capacity")
  `TMHQ_ASSERT_IMP(a_empty_zero, out_valid_q && out_status_q == ST_EMPTY,
                   out_count_q == '0 && out_min_key_q == '0, "bad empty result")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tmhq_pkg::*;

  localparam int HeapCap        = (DefaultCapacity < 255) ? DefaultCapacity : 255;
  localparam int PressureAt     = 600;
  localparam int PressureCycles = 400;
  localparam int DrainCycles    = 60;

  typedef struct packed {
    logic signed [KeyW-1:0] min_key;
    status_e                status;
    logic [7:0]             count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [KeyW-1:0] keys [StoreDepth];
    int unsigned            held;
    heap_result_t           expected_q [$];
    int                     errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [KeyW-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    function void note_request(kind_e kind, logic signed [KeyW-1:0] key);
      heap_result_t r;
      int unsigned  pos;
      int unsigned  up;
      int unsigned  best;
      int unsigned  c;
      bit           moving;
      r.min_key = '0;
      r.status  = ST_OK;
      if (kind == KIND_INSERT) begin
        if (held >= HeapCap) begin
          r.status = ST_FULL;
        end else begin
          held++;
          keys[held] = key;
          pos = held;
          moving = 1'b1;
          while (moving && pos > 1) begin
            up = (pos + 1) / 3;
            if (keys[pos] < keys[up]) begin
              swap_keys(pos, up);
              pos = up;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.min_key = keys[1];
          keys[1] = keys[held];
          held--;
          pos = 1;
          moving = 1'b1;
          while (moving) begin
            best = pos;
            for (c = 3 * pos - 1; c <= 3 * pos + 1; c++) begin
              if (c <= held && keys[c] < keys[best]) best = c;
            end
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              swap_keys(pos, best);
              pos = best;
            end
          end
        end
      end
      r.count = held[7:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [KeyW-1:0] min_key, logic [1:0] status,
                               logic [7:0] count);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: min_key %0d status %0d count %0d",
                 $time, min_key, status, count);
        return;
      end
      e = expected_q.pop_front();
      if (min_key !== e.min_key) begin
        errors++;
        $display("%0t: min_key mismatch: expected %0d actual %0d", $time, e.min_key, min_key);
      end
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
      end
      if (count !== e.count) begin
        errors++;
        $display("%0t: count mismatch: expected %0d actual %0d", $time, e.count, count);
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   in_kind_i   = 1'b0;
  logic signed [KeyW-1:0] in_key_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [KeyW-1:0] out_min_key_o;
  logic [1:0]             out_status_o;
  logic [7:0]             out_count_o;

  bit             no_idle = 1'b0;
  heap_scoreboard sb      = new();

  ternary_min_heap_queue_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_kind_i    (in_kind_i),
    .in_key_i     (in_key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_min_key_o(out_min_key_o),
    .out_status_o (out_status_o),
    .out_count_o  (out_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [KeyW-1:0] draw_key();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        v = $urandom_range(0, 15);
        return v - 8;
      end
      7: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      8: begin
        v = $urandom_range(0, 3);
        return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff - v : 32'sh80000000 + v;
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_item(kind_e kind, logic signed [KeyW-1:0] key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_key_i   <= key;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, key);
  endtask

  task automatic run_phase(int n, int insert_pct, bit burst);
    kind_e kind;
    no_idle = burst;
    repeat (n) begin
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT;
      send_item(kind, draw_key());
    end
  endtask

  // receive results; hold off once for a long stretch to back up the input
  initial begin : sink_proc
    int gap;
    int got;
    got = 0;
    @(posedge rst_ni);
    forever begin
      if (got == PressureAt) gap = PressureCycles;
      else gap = no_idle ? 0 : $urandom_range(0, 7);
      repeat (gap) @(negedge clk_i) out_stall_i <= 1'b1;
      @(negedge clk_i) out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_min_key_o, out_status_o, out_count_o);
      got++;
    end
  end

  initial begin : stim_proc
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_item(KIND_EXTRACT, 32'sh12345678);
    send_item(KIND_INSERT, 32'sh7fffffff);
    send_item(KIND_INSERT, 32'sh80000000);
    send_item(KIND_INSERT, 32'sh00000000);
    send_item(KIND_INSERT, -32'sd1);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, 32'sh80000000);
    send_item(KIND_INSERT, 32'sd1);
    repeat (10) send_item(KIND_EXTRACT, 32'shffffffff);
    send_item(KIND_INSERT, 32'sh55555555);
    send_item(KIND_INSERT, 32'shaaaaaaaa);

    run_phase(200, 60, 1'b0);
    run_phase(150, 50, 1'b1);
    run_phase(400, 95, 1'b0);
    run_phase(400, 5, 1'b0);
    run_phase(150, 50, 1'b1);
    run_phase(400, 95, 1'b0);

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** ternary_min_heap_queue_top: PASSED **");
    end else begin
      $display("** ternary_min_heap_queue_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("** ternary_min_heap_queue_top: FAILED **");
    $finish;
  end

endmodule
